FILE: rtl/tli_pkg.sv
package tli_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_START = 1'b1;
    localparam logic [1:0] SEL_ONE   = 2'd0;
    localparam logic [1:0] SEL_TWO   = 2'd1;
    localparam logic [1:0] SEL_THREE = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD1,
        OP_LOAD2,
        OP_LOAD3,
        OP_DROP,
        OP_START
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] value;
    } t_qent;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD3,
        ST_CAP3,
        ST_RD1,
        ST_CMP1,
        ST_RD2,
        ST_CMP2,
        ST_MATCH,
        ST_NEXT,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/three_list_intersection.sv
// channel | valid       | ready       | beat fields
// --------+-------------+-------------+------------------------------------------------
// in      | i_in_valid  | o_in_ready  | i_cmd, i_list_sel, i_elem_value
// out     | o_out_valid | i_out_ready | o_common_value, o_last_result, o_none_found,
//         |             |             | o_overflow_seen
//
// Loads retire one per cycle when idle; a 4-entry queue decouples input and list engine.
// Start: per third-list entry the engine scans the first list and, on a hit, the second
// list, one entry per RAM read; each RAM has a single registered read port.
// Reset clears counts, queue and output valid; list RAMs are not cleared.
// A held output beat stalls the engine; the queue keeps taking beats until full.
module three_list_intersection import tli_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_cmd,
    input  logic [1:0]               i_list_sel,
    input  logic signed [WORD_W-1:0] i_elem_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [WORD_W-1:0] o_common_value,
    output logic                     o_last_result,
    output logic                     o_none_found,
    output logic                     o_overflow_seen
);

    logic              q_valid;
    t_qent             q_ent;
    logic              pop;
    logic [WORD_W-1:0] common_value;

    tli_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_list_sel   (i_list_sel),
        .i_elem_value ($unsigned(i_elem_value)),
        .i_pop        (pop),
        .o_q_valid    (q_valid),
        .o_q_ent      (q_ent)
    );

    tli_back #(.DEPTH(DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_ent         (q_ent),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_common_value  (common_value),
        .o_last_result   (o_last_result),
        .o_none_found    (o_none_found),
        .o_overflow_seen (o_overflow_seen)
    );

    assign o_common_value = $signed(common_value);

endmodule

FILE: rtl/tli_ram.sv
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tli_front.sv
module tli_front import tli_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [1:0]        i_list_sel,
    input  logic [WORD_W-1:0] i_elem_value,
    input  logic              i_pop,
    output logic              o_q_valid,
    output t_qent             o_q_ent
);

    t_qent          ent;
    t_qent          r_q [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_cnt;
    logic           push;
    logic           pop;

    always_comb begin
        ent.value = i_elem_value;
        ent.op    = OP_DROP;
        if (i_cmd == CMD_START) begin
            ent.op = OP_START;
        end else begin
            unique case (i_list_sel)
                SEL_ONE:   ent.op = OP_LOAD1;
                SEL_TWO:   ent.op = OP_LOAD2;
                SEL_THREE: ent.op = OP_LOAD3;
                default:   ent.op = OP_DROP;
            endcase
        end
    end

    assign o_in_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_ent    = r_q[r_rptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/tli_back.sv
module tli_back import tli_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_qent             i_q_ent,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_common_value,
    output logic              o_last_result,
    output logic              o_none_found,
    output logic              o_overflow_seen
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt1, n_cnt1;
    logic [CW-1:0]     r_cnt2, n_cnt2;
    logic [CW-1:0]     r_cnt3, n_cnt3;
    logic              r_ovf, n_ovf;
    logic              r_have, n_have;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_k, n_k;
    logic [WORD_W-1:0] r_v, n_v;
    logic [WORD_W-1:0] r_pend, n_pend;
    logic              r_out_vld, n_out_vld;
    logic [WORD_W-1:0] r_out_val, n_out_val;
    logic              r_out_last, n_out_last;
    logic              r_out_nf, n_out_nf;
    logic              r_out_ovf, n_out_ovf;

    logic              emit_ok;
    logic              we1, we2, we3;
    logic [WORD_W-1:0] rdata1, rdata2, rdata3;

    tli_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_cnt1[AW-1:0]),
        .i_wdata (i_q_ent.value),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (rdata1)
    );

    tli_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram2 (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_cnt2[AW-1:0]),
        .i_wdata (i_q_ent.value),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (rdata2)
    );

    tli_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram3 (
        .i_clk   (i_clk),
        .i_we    (we3),
        .i_waddr (r_cnt3[AW-1:0]),
        .i_wdata (i_q_ent.value),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (rdata3)
    );

    assign emit_ok = !r_out_vld || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt1     = r_cnt1;
        n_cnt2     = r_cnt2;
        n_cnt3     = r_cnt3;
        n_ovf      = r_ovf;
        n_have     = r_have;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_v        = r_v;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_val  = r_out_val;
        n_out_last = r_out_last;
        n_out_nf   = r_out_nf;
        n_out_ovf  = r_out_ovf;
        o_pop      = 1'b0;
        we1        = 1'b0;
        we2        = 1'b0;
        we3        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    unique case (i_q_ent.op)
                        OP_LOAD1: begin
                            if (r_cnt1 == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                we1    = 1'b1;
                                n_cnt1 = r_cnt1 + 1'b1;
                            end
                        end
                        OP_LOAD2: begin
                            if (r_cnt2 == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                we2    = 1'b1;
                                n_cnt2 = r_cnt2 + 1'b1;
                            end
                        end
                        OP_LOAD3: begin
                            if (r_cnt3 == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                we3    = 1'b1;
                                n_cnt3 = r_cnt3 + 1'b1;
                            end
                        end
                        OP_START: begin
                            n_have  = 1'b0;
                            n_i     = '0;
                            n_state = (r_cnt3 == '0) ? ST_FINISH : ST_RD3;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD3: begin
                n_state = ST_CAP3;
            end
            ST_CAP3: begin
                n_v     = rdata3;
                n_j     = '0;
                n_state = (r_cnt1 == '0) ? ST_NEXT : ST_RD1;
            end
            ST_RD1: begin
                n_state = ST_CMP1;
            end
            ST_CMP1: begin
                if (rdata1 == r_v) begin
                    n_k     = '0;
                    n_state = (r_cnt2 == '0) ? ST_NEXT : ST_RD2;
                end else if ((r_j + CW'(1)) == r_cnt1) begin
                    n_state = ST_NEXT;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_RD1;
                end
            end
            ST_RD2: begin
                n_state = ST_CMP2;
            end
            ST_CMP2: begin
                if (rdata2 == r_v) begin
                    n_state = ST_MATCH;
                end else if ((r_k + CW'(1)) == r_cnt2) begin
                    n_state = ST_NEXT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_RD2;
                end
            end
            ST_MATCH: begin
                // previous match is known not to be last once a new one shows up
                if (!r_have) begin
                    n_pend  = r_v;
                    n_have  = 1'b1;
                    n_state = ST_NEXT;
                end else if (emit_ok) begin
                    n_out_vld  = 1'b1;
                    n_out_val  = r_pend;
                    n_out_last = 1'b0;
                    n_out_nf   = 1'b0;
                    n_out_ovf  = r_ovf;
                    n_pend     = r_v;
                    n_state    = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if ((r_i + CW'(1)) == r_cnt3) begin
                    n_state = ST_FINISH;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_RD3;
                end
            end
            ST_FINISH: begin
                if (emit_ok) begin
                    n_out_vld  = 1'b1;
                    n_out_val  = r_have ? r_pend : '0;
                    n_out_last = 1'b1;
                    n_out_nf   = !r_have;
                    n_out_ovf  = r_ovf;
                    n_cnt1     = '0;
                    n_cnt2     = '0;
                    n_cnt3     = '0;
                    n_ovf      = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt1    <= '0;
            r_cnt2    <= '0;
            r_cnt3    <= '0;
            r_ovf     <= 1'b0;
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt1    <= n_cnt1;
            r_cnt2    <= n_cnt2;
            r_cnt3    <= n_cnt3;
            r_ovf     <= n_ovf;
            r_have    <= n_have;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_v        <= n_v;
        r_pend     <= n_pend;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        r_out_nf   <= n_out_nf;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out_valid     = r_out_vld;
    assign o_common_value  = r_out_val;
    assign o_last_result   = r_out_last;
    assign o_none_found    = r_out_nf;
    assign o_overflow_seen = r_out_ovf;

endmodule

FILE: rtl/tli_checker.sv
module tli_checker import tli_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [WORD_W-1:0] o_common_value,
    input logic                     o_last_result,
    input logic                     o_none_found,
    input logic                     o_overflow_seen
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_common_value) && $stable(o_last_result)
            && $stable(o_none_found) && $stable(o_overflow_seen))
        else $error("output payload changed while stalled");

    a_none_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_found |-> o_last_result && (o_common_value == '0))
        else $error("none-found beat malformed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind three_list_intersection tli_checker u_chk (.*);

FILE: dv/testbench.sv
module testbench import tli_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int RAND_ITEMS   = 40;

    localparam logic [WORD_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] VAL_NEG = 32'hFFFF_FFFF;
    localparam logic [1:0]        SEL_NONE = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
        logic              none;
        logic              ovf;
    } t_hit;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_cmd;
    logic [1:0]               i_list_sel;
    logic signed [WORD_W-1:0] i_elem_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [WORD_W-1:0] o_common_value;
    logic                     o_last_result;
    logic                     o_none_found;
    logic                     o_overflow_seen;

    three_list_intersection dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_list_sel     (i_list_sel),
        .i_elem_value   (i_elem_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_common_value (o_common_value),
        .o_last_result  (o_last_result),
        .o_none_found   (o_none_found),
        .o_overflow_seen(o_overflow_seen)
    );

    // predictor state
    logic [WORD_W-1:0] list_mem [3][DEPTH_DEF];
    int                list_len [3];
    bit                dropped_load;
    t_hit              expected_hits[$];

    int  mismatches   = 0;
    int  beats_in     = 0;
    int  hits_seen    = 0;
    int  runs_done    = 0;
    int  empty_runs   = 0;
    int  ovf_runs     = 0;
    bit  tx_burst     = 0;
    bit  hold_request = 0;

    logic in_beat;
    logic out_beat;
    assign in_beat  = i_rst_n && i_in_valid && (o_in_ready === 1'b1);
    assign out_beat = i_rst_n && i_out_ready && (o_out_valid === 1'b1);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit list_holds(int which, logic [WORD_W-1:0] v);
        for (int k = 0; k < list_len[which]; k++) begin
            if (list_mem[which][k] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_intersection(logic cmd, logic [1:0] sel,
                                                 logic [WORD_W-1:0] val);
        t_hit run_hits[$];
        t_hit h;
        int   which;
        if (cmd == CMD_LOAD) begin
            case (sel)
                SEL_ONE, SEL_TWO, SEL_THREE: begin
                    which = int'(sel);
                    if (list_len[which] >= DEPTH_DEF) begin
                        dropped_load = 1'b1;
                    end else begin
                        list_mem[which][list_len[which]] = val;
                        list_len[which]++;
                    end
                end
                default: ;
            endcase
        end else begin
            for (int k = 0; k < list_len[SEL_THREE]; k++) begin
                h.value = list_mem[SEL_THREE][k];
                if (list_holds(SEL_ONE, h.value) && list_holds(SEL_TWO, h.value)) begin
                    h.last = 1'b0;
                    h.none = 1'b0;
                    h.ovf  = dropped_load;
                    run_hits = {run_hits, h};
                end
            end
            if (run_hits.size() == 0) begin
                h.value = '0;
                h.last  = 1'b1;
                h.none  = 1'b1;
                h.ovf   = dropped_load;
                run_hits = {run_hits, h};
            end else begin
                run_hits[run_hits.size()-1].last = 1'b1;
            end
            expected_hits = {expected_hits, run_hits};
            list_len[SEL_ONE]   = 0;
            list_len[SEL_TWO]   = 0;
            list_len[SEL_THREE] = 0;
            dropped_load        = 1'b0;
        end
    endfunction

    // checker: output beat is compared before the same-edge input beat is predicted
    always @(posedge i_clk) begin
        t_hit want;
        if (out_beat) begin
            hits_seen++;
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %0d last %0b none %0b ovf %0b",
                             o_common_value, o_last_result, o_none_found, o_overflow_seen);
            end else begin
                want = expected_hits.pop_front();
                if (want.last) runs_done++;
                if (want.none) empty_runs++;
                if (want.last && want.ovf) ovf_runs++;
                if (o_common_value !== want.value || o_last_result !== want.last ||
                    o_none_found !== want.none || o_overflow_seen !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                    "mismatch (value/last/none/ovf): expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                            $signed(want.value), want.last, want.none, want.ovf,
                            o_common_value, o_last_result, o_none_found,
                            o_overflow_seen);
                end
            end
        end
        if (in_beat) begin
            beats_in++;
            predict_intersection(i_cmd, i_list_sel, i_elem_value);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_beat || out_beat) idle = 0;
            else idle++;
        end
        $display("no beat moved for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, burst stretches, and the long hold on request
    initial begin
        int stall;
        int beats_in_mode;
        bit rx_burst;
        i_out_ready   = 1'b0;
        beats_in_mode = 0;
        rx_burst      = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (beats_in_mode == 0) begin
                rx_burst      = ($urandom_range(0, 3) == 0);
                beats_in_mode = 16;
            end
            beats_in_mode--;
            stall = rx_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1 && !hold_request);
            @(negedge i_clk);
        end
    end

    // entered and left on a falling edge
    task automatic send_beat(logic cmd, logic [1:0] sel, logic [WORD_W-1:0] val);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_list_sel   <= sel;
        i_elem_value <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic send_start();
        send_beat(CMD_START, 2'($urandom_range(0, 3)), $urandom);
    endtask

    task automatic test_empty_lists();
        send_start();
    endtask

    task automatic test_extreme_values();
        send_beat(CMD_LOAD, SEL_ONE, VAL_MIN);
        send_beat(CMD_LOAD, SEL_ONE, VAL_MAX);
        send_beat(CMD_LOAD, SEL_ONE, '0);
        send_beat(CMD_LOAD, SEL_ONE, VAL_NEG);
        send_beat(CMD_LOAD, SEL_TWO, VAL_NEG);
        send_beat(CMD_LOAD, SEL_TWO, VAL_MAX);
        send_beat(CMD_LOAD, SEL_TWO, VAL_MIN);
        send_beat(CMD_LOAD, SEL_TWO, 32'd5);
        send_beat(CMD_LOAD, SEL_THREE, VAL_MAX);
        send_beat(CMD_LOAD, SEL_THREE, 32'd7);
        send_beat(CMD_LOAD, SEL_THREE, VAL_MIN);
        send_beat(CMD_LOAD, SEL_THREE, VAL_MAX);
        send_beat(CMD_LOAD, SEL_THREE, VAL_NEG);
        send_beat(CMD_LOAD, SEL_THREE, '0);
        send_start();
    endtask

    task automatic test_no_common();
        send_beat(CMD_LOAD, SEL_ONE, 32'd1);
        send_beat(CMD_LOAD, SEL_TWO, 32'd2);
        send_beat(CMD_LOAD, SEL_THREE, 32'd1);
        send_start();
    endtask

    task automatic test_ignored_select();
        send_beat(CMD_LOAD, SEL_NONE, 32'd9);
        send_beat(CMD_LOAD, SEL_ONE, 32'd9);
        send_beat(CMD_LOAD, SEL_TWO, 32'd9);
        send_beat(CMD_LOAD, SEL_NONE, 32'd3);
        send_beat(CMD_LOAD, SEL_THREE, 32'd9);
        send_start();
    endtask

    // every list one past full; third list yields the largest possible run
    task automatic test_list_overflow();
        logic [WORD_W-1:0] pool [8];
        foreach (pool[k]) pool[k] = $urandom;
        for (int k = 0; k <= DEPTH_DEF; k++) begin
            send_beat(CMD_LOAD, SEL_ONE, pool[k % 8]);
            send_beat(CMD_LOAD, SEL_TWO, pool[(k + 3) % 8]);
            send_beat(CMD_LOAD, SEL_THREE, pool[$urandom_range(0, 7)]);
        end
        send_start();
        send_start();
    endtask

    task automatic test_output_stall();
        tx_burst     = 1'b1;
        hold_request = 1'b1;
        for (int k = 0; k < 8; k++) begin
            send_beat(CMD_LOAD, SEL_ONE, 32'(100 + k));
            send_beat(CMD_LOAD, SEL_TWO, 32'(107 - k));
            send_beat(CMD_LOAD, SEL_THREE, 32'(100 + k));
        end
        send_start();
        for (int k = 0; k < 12; k++) send_beat(CMD_LOAD, 2'(k % 3), 32'(k % 4));
        send_start();
        tx_burst = 1'b0;
    endtask

    task automatic test_random();
        logic [WORD_W-1:0] pool [8];
        int                pool_n;
        int                left [3];
        int                total;
        int                s;
        int                done;
        logic [WORD_W-1:0] v;
        done = 0;
        while (done < RAND_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                // noise: random commands, including the unused select
                repeat ($urandom_range(1, 4)) begin
                    s = $urandom_range(0, 3);
                    if ($urandom_range(0, 4) == 0) begin
                        send_beat(CMD_START, 2'(s), $urandom);
                        done++;
                    end else begin
                        send_beat(CMD_LOAD, 2'(s), $urandom);
                        if (2'(s) != SEL_NONE) done++;
                    end
                end
            end else begin
                pool_n = $urandom_range(1, 8);
                for (int k = 0; k < pool_n; k++) begin
                    case ($urandom_range(0, 9))
                        0:       pool[k] = VAL_MIN;
                        1:       pool[k] = VAL_MAX;
                        2:       pool[k] = '0;
                        3:       pool[k] = VAL_NEG;
                        default: pool[k] = $urandom;
                    endcase
                end
                total = 0;
                for (int k = 0; k < 3; k++) begin
                    left[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                         : $urandom_range(0, 6);
                    total += left[k];
                end
                while (total > 0) begin
                    do s = $urandom_range(0, 2); while (left[s] == 0);
                    v = ($urandom_range(0, 4) == 0) ? $urandom
                                                    : pool[$urandom_range(0, pool_n - 1)];
                    if ($urandom_range(0, 11) == 0) send_beat(CMD_LOAD, SEL_NONE, $urandom);
                    send_beat(CMD_LOAD, 2'(s), v);
                    left[s]--;
                    total--;
                    done++;
                end
                send_start();
                done++;
            end
        end
        tx_burst = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_LOAD;
        i_list_sel   = SEL_ONE;
        i_elem_value = '0;
        list_len     = '{0, 0, 0};
        dropped_load = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_lists();
        test_extreme_values();
        test_no_common();
        test_ignored_select();
        test_list_overflow();
        test_output_stall();
        test_random();

        i_in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input beats, %0d result beats over %0d runs", beats_in, hits_seen,
                 runs_done);
        $display("%0d runs with no common value, %0d runs after dropped loads, %0d mismatches",
                 empty_runs, ovf_runs, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/tli_front.sv
rtl/tli_back.sv
rtl/three_list_intersection.sv
rtl/tli_checker.sv
dv/testbench.sv
